@@ hdl/wfsm_pkg.sv @@
// ----------------------------------------------------------------------------
// wfsm_pkg: shared types and constants of the frame statistics monitor
// Widths, reset values, the job record between front and back, and the
// back-end sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package wfsm_pkg;

	localparam int TIME_W  = 24;
	localparam int COUNT_W = 16;
	localparam int SUM_W   = 32;

	// rate = tally * 1000 * 2^16 / elapsed (both times carry 8 fraction bits)
	localparam int SCALE_W = 26;
	localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(65536000);

	// divider: numerator wide enough for the rate product and the time sum
	localparam int DIVN_W  = COUNT_W + SCALE_W;
	localparam int DIVHI_W = DIVN_W - TIME_W;
	localparam int DIVC_W  = (DIVHI_W > SUM_W) ? DIVHI_W : SUM_W;
	localparam int DIVK_W  = $clog2(TIME_W);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [TIME_W-1:0]        time_t;
	typedef logic signed [TIME_W-1:0] stime_t;
	typedef logic [COUNT_W-1:0]       cnt_t;
	typedef logic [SUM_W-1:0]         sum_t;
	typedef logic [DIVN_W-1:0]        divn_t;
	typedef logic [DIVC_W-1:0]        divc_t;
	typedef logic [DIVK_W-1:0]        divk_t;
	typedef logic [QPTR_W-1:0]        qptr_t;
	typedef logic [QCNT_W-1:0]        qcnt_t;

	localparam time_t  WINDOW_RESET = time_t'(256000);
	localparam stime_t SPARE_MAX    = {1'b0, {(TIME_W-1){1'b1}}};
	localparam time_t  TIME_MAX     = '1;

	// one classified item handed from front to back
	typedef struct packed {
		logic   publish;
		cnt_t   tally;
		sum_t   elapsed;
		sum_t   fsum;
		time_t  longest;
		stime_t spare;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_RSTART,
		BK_RWAIT,
		BK_MSTART,
		BK_MWAIT,
		BK_EMIT
	} bk_state_t;

endpackage

`default_nettype wire

@@ hdl/wfsm_if.sv @@
// ----------------------------------------------------------------------------
// wfsm_if: item channels of the frame statistics monitor
// Frame report channel and statistics result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wfsm_in_if;
	logic               valid;
	logic               ready;
	wfsm_pkg::time_t    delta_time;
	wfsm_pkg::time_t    frame_time;
	wfsm_pkg::stime_t   slack_time;

	modport source (output valid, output delta_time, output frame_time,
		output slack_time, input ready);
	modport sink (input valid, input delta_time, input frame_time,
		input slack_time, output ready);
endinterface

interface wfsm_out_if;
	logic               valid;
	logic               ready;
	logic               published;
	wfsm_pkg::time_t    average_rate;
	wfsm_pkg::time_t    average_frame_time;
	wfsm_pkg::time_t    worst_frame_time;
	wfsm_pkg::stime_t   least_slack_time;

	modport source (output valid, output published, output average_rate,
		output average_frame_time, output worst_frame_time,
		output least_slack_time, input ready);
	modport sink (input valid, input published, input average_rate,
		input average_frame_time, input worst_frame_time,
		input least_slack_time, output ready);
endinterface

`default_nettype wire

@@ hdl/wfsm_front.sv @@
// ----------------------------------------------------------------------------
// wfsm_front: accumulator front end
// Accepts frame reports, updates the window accumulators, decides whether
// the item closes the window and pushes a job to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wfsm_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	wfsm_in_if.sink              frames,
	input  wire logic            cfg_we,
	input  wire wfsm_pkg::time_t cfg_wdata,
	input  wire logic            q_full,
	output logic                 push,
	output wfsm_pkg::job_t       push_job
);

	wfsm_pkg::time_t  window_q;
	wfsm_pkg::sum_t   elapsed_q;
	wfsm_pkg::cnt_t   tally_q;
	wfsm_pkg::sum_t   fsum_q;
	wfsm_pkg::time_t  longest_q;
	wfsm_pkg::stime_t spare_q;

	logic [wfsm_pkg::SUM_W:0] elapsed_add;
	logic [wfsm_pkg::SUM_W:0] fsum_add;
	wfsm_pkg::sum_t   elapsed_nx;
	wfsm_pkg::sum_t   fsum_nx;
	wfsm_pkg::cnt_t   tally_nx;
	wfsm_pkg::time_t  longest_nx;
	wfsm_pkg::stime_t spare_nx;
	logic             close_win;

	assign frames.ready = !q_full;
	assign push         = frames.valid && !q_full;

	always_comb begin
		elapsed_add = {1'b0, elapsed_q} + (wfsm_pkg::SUM_W + 1)'(frames.delta_time);
		fsum_add    = {1'b0, fsum_q} + (wfsm_pkg::SUM_W + 1)'(frames.frame_time);
		elapsed_nx  = elapsed_add[wfsm_pkg::SUM_W] ? '1 : elapsed_add[wfsm_pkg::SUM_W-1:0];
		fsum_nx     = fsum_add[wfsm_pkg::SUM_W] ? '1 : fsum_add[wfsm_pkg::SUM_W-1:0];
		tally_nx    = (tally_q == '1) ? tally_q : tally_q + 1'b1;
		longest_nx  = (frames.frame_time > longest_q) ? frames.frame_time : longest_q;
		spare_nx    = (frames.slack_time < spare_q) ? frames.slack_time : spare_q;
		close_win   = elapsed_nx >= wfsm_pkg::sum_t'(window_q);

		push_job.publish = close_win;
		push_job.tally   = tally_nx;
		push_job.elapsed = elapsed_nx;
		push_job.fsum    = fsum_nx;
		push_job.longest = longest_nx;
		push_job.spare   = spare_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= wfsm_pkg::WINDOW_RESET;
			elapsed_q <= '0;
			tally_q   <= '0;
			fsum_q    <= '0;
			longest_q <= '0;
			spare_q   <= wfsm_pkg::SPARE_MAX;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (push) begin
				if (close_win) begin
					elapsed_q <= '0;
					tally_q   <= '0;
					fsum_q    <= '0;
					longest_q <= '0;
					spare_q   <= wfsm_pkg::SPARE_MAX;
				end else begin
					elapsed_q <= elapsed_nx;
					tally_q   <= tally_nx;
					fsum_q    <= fsum_nx;
					longest_q <= longest_nx;
					spare_q   <= spare_nx;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/wfsm_fifo.sv @@
// ----------------------------------------------------------------------------
// wfsm_fifo: job queue between front and back
// Small flop-based FIFO of classified items.
// ----------------------------------------------------------------------------
`default_nettype none

module wfsm_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire wfsm_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                vld,
	output wfsm_pkg::job_t      pop_job
);

	wfsm_pkg::job_t  mem_q [wfsm_pkg::QDEPTH];
	wfsm_pkg::qptr_t wr_q;
	wfsm_pkg::qptr_t rd_q;
	wfsm_pkg::qcnt_t cnt_q;

	assign full    = cnt_q == wfsm_pkg::qcnt_t'(wfsm_pkg::QDEPTH);
	assign vld     = cnt_q != '0;
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == wfsm_pkg::qptr_t'(wfsm_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == wfsm_pkg::qptr_t'(wfsm_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("job pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> vld)
		else $error("job popped from empty queue");

endmodule

`default_nettype wire

@@ hdl/wfsm_div.sv @@
// ----------------------------------------------------------------------------
// wfsm_div: shared restoring divider
// One quotient bit per cycle; a quotient that cannot fit the time width is
// caught up front and returned as all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module wfsm_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire wfsm_pkg::divn_t num,
	input  wire wfsm_pkg::sum_t  den,
	output logic                 done,
	output wfsm_pkg::time_t      quot
);

	logic            busy_q;
	logic            done_q;
	wfsm_pkg::divk_t cnt_q;
	wfsm_pkg::sum_t  rem_q;
	wfsm_pkg::sum_t  den_q;
	wfsm_pkg::time_t nlo_q;
	wfsm_pkg::time_t quot_q;

	logic [wfsm_pkg::DIVHI_W-1:0] num_hi;
	logic                         sat;
	logic [wfsm_pkg::SUM_W+1:0]   trial_ext;
	logic [wfsm_pkg::SUM_W+1:0]   trial_sub;
	logic                         fits;

	assign done = done_q;
	assign quot = quot_q;

	always_comb begin
		num_hi    = num[wfsm_pkg::DIVN_W-1:wfsm_pkg::TIME_W];
		// quotient overflows the time width when num / 2^TIME_W >= den
		sat       = wfsm_pkg::divc_t'(num_hi) >= wfsm_pkg::divc_t'(den);
		trial_ext = {1'b0, rem_q, nlo_q[wfsm_pkg::TIME_W-1]};
		trial_sub = trial_ext - {2'b00, den_q};
		fits      = !trial_sub[wfsm_pkg::SUM_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wfsm_pkg::divk_t'(wfsm_pkg::TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			nlo_q <= num[wfsm_pkg::TIME_W-1:0];
			rem_q <= wfsm_pkg::sum_t'(num_hi);
			if (sat) begin
				quot_q <= wfsm_pkg::TIME_MAX;
			end
		end else if (busy_q) begin
			rem_q  <= fits ? trial_sub[wfsm_pkg::SUM_W-1:0] : trial_ext[wfsm_pkg::SUM_W-1:0];
			quot_q <= {quot_q[wfsm_pkg::TIME_W-2:0], fits};
			nlo_q  <= {nlo_q[wfsm_pkg::TIME_W-2:0], 1'b0};
		end
	end

endmodule

`default_nettype wire

@@ hdl/wfsm_back.sv @@
// ----------------------------------------------------------------------------
// wfsm_back: publishing back end
// Pops jobs, runs the rate and mean divisions for items that close a window,
// keeps the published values and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wfsm_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_vld,
	input  wire wfsm_pkg::job_t q_job,
	output logic                pop,
	wfsm_out_if.source          stats
);

	wfsm_pkg::bk_state_t state_q;
	wfsm_pkg::bk_state_t state_nx;

	wfsm_pkg::job_t   job_q;
	wfsm_pkg::divn_t  prod_q;
	wfsm_pkg::time_t  rate_q;
	wfsm_pkg::time_t  mean_q;
	wfsm_pkg::time_t  shown_rate_q;
	wfsm_pkg::time_t  shown_mean_q;
	wfsm_pkg::time_t  shown_longest_q;
	wfsm_pkg::stime_t shown_spare_q;

	logic             out_vld_q;
	logic             out_pub_q;
	wfsm_pkg::time_t  out_rate_q;
	wfsm_pkg::time_t  out_mean_q;
	wfsm_pkg::time_t  out_longest_q;
	wfsm_pkg::stime_t out_spare_q;

	logic out_free;
	logic load_job;
	logic load_prod;
	logic div_start;
	logic div_mean;
	logic grab_rate;
	logic grab_mean;
	logic emit_plain;
	logic emit_pub;

	wfsm_pkg::divn_t div_num;
	wfsm_pkg::sum_t  div_den;
	logic            div_done;
	wfsm_pkg::time_t div_quot;

	assign out_free = !out_vld_q || stats.ready;

	assign stats.valid              = out_vld_q;
	assign stats.published          = out_pub_q;
	assign stats.average_rate       = out_rate_q;
	assign stats.average_frame_time = out_mean_q;
	assign stats.worst_frame_time   = out_longest_q;
	assign stats.least_slack_time   = out_spare_q;

	assign div_num = div_mean ? wfsm_pkg::divn_t'(job_q.fsum) : prod_q;
	assign div_den = div_mean ? wfsm_pkg::sum_t'(job_q.tally) : job_q.elapsed;

	wfsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			wfsm_pkg::BK_IDLE: begin
				if (q_vld && out_free && q_job.publish) begin
					state_nx = wfsm_pkg::BK_MUL;
				end
			end
			wfsm_pkg::BK_MUL:    state_nx = wfsm_pkg::BK_RSTART;
			wfsm_pkg::BK_RSTART: state_nx = wfsm_pkg::BK_RWAIT;
			wfsm_pkg::BK_RWAIT: begin
				if (div_done) begin
					state_nx = wfsm_pkg::BK_MSTART;
				end
			end
			wfsm_pkg::BK_MSTART: state_nx = wfsm_pkg::BK_MWAIT;
			wfsm_pkg::BK_MWAIT: begin
				if (div_done) begin
					state_nx = wfsm_pkg::BK_EMIT;
				end
			end
			wfsm_pkg::BK_EMIT: begin
				if (out_free) begin
					state_nx = wfsm_pkg::BK_IDLE;
				end
			end
			default: state_nx = wfsm_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		load_job   = 1'b0;
		load_prod  = 1'b0;
		div_start  = 1'b0;
		div_mean   = 1'b0;
		grab_rate  = 1'b0;
		grab_mean  = 1'b0;
		emit_plain = 1'b0;
		emit_pub   = 1'b0;
		unique case (state_q)
			wfsm_pkg::BK_IDLE: begin
				if (q_vld && out_free) begin
					pop        = 1'b1;
					load_job   = q_job.publish;
					emit_plain = !q_job.publish;
				end
			end
			wfsm_pkg::BK_MUL:    load_prod = 1'b1;
			wfsm_pkg::BK_RSTART: div_start = 1'b1;
			wfsm_pkg::BK_RWAIT:  grab_rate = div_done;
			wfsm_pkg::BK_MSTART: begin
				div_start = 1'b1;
				div_mean  = 1'b1;
			end
			wfsm_pkg::BK_MWAIT: begin
				div_mean  = 1'b1;
				grab_mean = div_done;
			end
			wfsm_pkg::BK_EMIT:   emit_pub = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= wfsm_pkg::BK_IDLE;
			out_vld_q       <= 1'b0;
			shown_rate_q    <= '0;
			shown_mean_q    <= '0;
			shown_longest_q <= '0;
			shown_spare_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (emit_plain || emit_pub) begin
				out_vld_q <= 1'b1;
			end else if (stats.ready) begin
				out_vld_q <= 1'b0;
			end
			if (emit_pub) begin
				shown_rate_q    <= rate_q;
				shown_mean_q    <= mean_q;
				shown_longest_q <= job_q.longest;
				shown_spare_q   <= job_q.spare;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_job) begin
			job_q <= q_job;
		end
		if (load_prod) begin
			prod_q <= wfsm_pkg::divn_t'(job_q.tally) * wfsm_pkg::divn_t'(wfsm_pkg::RATE_SCALE);
		end
		if (grab_rate) begin
			rate_q <= div_quot;
		end
		if (grab_mean) begin
			mean_q <= div_quot;
		end
		if (emit_pub) begin
			out_pub_q     <= 1'b1;
			out_rate_q    <= rate_q;
			out_mean_q    <= mean_q;
			out_longest_q <= job_q.longest;
			out_spare_q   <= job_q.spare;
		end else if (emit_plain) begin
			out_pub_q     <= 1'b0;
			out_rate_q    <= shown_rate_q;
			out_mean_q    <= shown_mean_q;
			out_longest_q <= shown_longest_q;
			out_spare_q   <= shown_spare_q;
		end
	end

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == wfsm_pkg::BK_RWAIT || state_q == wfsm_pkg::BK_MWAIT))
		else $error("divider finished with no division pending");

	// while the tally counts every frame, the (possibly saturated) sum cannot
	// average above the longest frame; a saturated tally lets the sum run ahead
	a_mean_le_worst: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_pub && job_q.tally != '1) |-> (mean_q <= job_q.longest))
		else $error("published mean frame time exceeds worst frame time");

endmodule

`default_nettype wire

@@ hdl/windowed_frame_stats_monitor_core.sv @@
// ----------------------------------------------------------------------------
// windowed_frame_stats_monitor_core: windowed frame statistics monitor
// Sums frame reports over a time window and publishes rate, mean frame time,
// worst frame time and least spare time each time the window closes.
// ----------------------------------------------------------------------------
// Usage:
//  frames: one frame report per item (delta, frame time, signed spare time,
//  all Q16.8 ms). stats: one result item per frame item, in order, with the
//  currently published values and a flag set when that item closed a window.
//  cfg_we/cfg_wdata write the window length; write only while idle.
// Flow: the front updates the accumulators in the accept cycle
//  and queues the item (two-entry queue). An item that does not close the
//  window goes through the queue and the result register to stats; frames keep flowing at
//  one item per cycle while stats is taken. An item that closes the window
//  runs the shared bit-serial divider twice (rate, then mean) after a
//  multiply state; a saturating quotient ends its division early. The front
//  keeps accepting until the queue fills.
// Reset: accumulators clear, the spare minimum goes to the largest positive
//  value, published values read zero, window length is 1000 ms.
// Stall: a stalled stats holds its item; the queue fills and frames.ready
//  drops. No item is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_frame_stats_monitor_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	wfsm_in_if.sink              frames,
	wfsm_out_if.source           stats,
	input  wire logic            cfg_we,
	input  wire wfsm_pkg::time_t cfg_wdata
);

	logic           push;
	wfsm_pkg::job_t push_job;
	logic           q_full;
	logic           pop;
	logic           q_vld;
	wfsm_pkg::job_t q_job;

	wfsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.frames    (frames),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	wfsm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.vld      (q_vld),
		.pop_job  (q_job)
	);

	wfsm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_vld  (q_vld),
		.q_job  (q_job),
		.pop    (pop),
		.stats  (stats)
	);

endmodule

`default_nettype wire

@@ tb/tb_windowed_frame_stats_monitor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_frame_stats_monitor_core: frame statistics monitor testbench
// Drives frame reports through the valid/ready channel and predicts every
// stats item from its own copy of the window accumulators. It covers field
// extremes, a zero window, the minimum and maximum windows, and the
// saturation of the frame-time sum and the rate. Random traffic then runs
// under several window lengths and idle patterns, including a long stall on
// the stats side.
// ----------------------------------------------------------------------------

module tb_windowed_frame_stats_monitor_core;

	import wfsm_pkg::*;

	localparam int     CLK_HALF     = 4;
	localparam int     CYCLE_LIMIT  = 3000000;
	localparam int     DRAIN_LIMIT  = 20000;
	localparam int     SETTLE       = 80;
	localparam int     HOLD_CYCLES  = 400;
	localparam int     PHASE_ITEMS  = 120;
	localparam stime_t SPARE_MIN    = {1'b1, {(TIME_W-1){1'b0}}};

	typedef struct packed {
		logic   published;
		time_t  average_rate;
		time_t  average_frame_time;
		time_t  worst_frame_time;
		stime_t least_slack_time;
	} stats_rec_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	time_t cfg_wdata;

	wfsm_in_if  frames_ch ();
	wfsm_out_if stats_ch ();

	windowed_frame_stats_monitor_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frames    (frames_ch),
		.stats     (stats_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	time_t  win_len;
	sum_t   acc_elapsed;
	cnt_t   acc_tally;
	sum_t   acc_fsum;
	time_t  acc_longest;
	stime_t acc_least;
	time_t  shown_rate;
	time_t  shown_mean;
	time_t  shown_worst;
	stime_t shown_least;

	stats_rec_t pending_stats[$];

	int fail_count     = 0;
	int items_sent     = 0;
	int stats_checked  = 0;
	int windows_closed = 0;
	int snd_idle_pct   = 0;
	int rcv_idle_pct   = 0;
	int hold_gen       = 0;
	int cycle_count    = 0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	task automatic clear_accumulators();
		acc_elapsed = '0;
		acc_tally   = '0;
		acc_fsum    = '0;
		acc_longest = '0;
		acc_least   = SPARE_MAX;
	endtask

	// one frame report into the predicted window; returns the stats item
	task automatic fold_frame(input time_t d, input time_t f, input stime_t s,
			output stats_rec_t r);
		logic [SUM_W:0] wide;
		logic [63:0]    quo;
		wide = {1'b0, acc_elapsed} + d;
		acc_elapsed = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
		if (acc_tally != '1)
			acc_tally = acc_tally + 1'b1;
		wide = {1'b0, acc_fsum} + f;
		acc_fsum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
		if (f > acc_longest)
			acc_longest = f;
		if (s < acc_least)
			acc_least = s;
		r.published = 1'b0;
		if (acc_elapsed >= sum_t'(win_len)) begin
			// zero elapsed only happens with a zero window
			if (acc_elapsed == '0)
				quo = 64'(TIME_MAX);
			else
				quo = (64'(acc_tally) * 64'd65536000) / 64'(acc_elapsed);
			shown_rate = (quo > 64'(TIME_MAX)) ? TIME_MAX : time_t'(quo);
			quo = 64'(acc_fsum) / 64'(acc_tally);
			shown_mean = (quo > 64'(TIME_MAX)) ? TIME_MAX : time_t'(quo);
			shown_worst = acc_longest;
			shown_least = acc_least;
			clear_accumulators();
			r.published = 1'b1;
		end
		r.average_rate       = shown_rate;
		r.average_frame_time = shown_mean;
		r.worst_frame_time   = shown_worst;
		r.least_slack_time   = shown_least;
	endtask

	task automatic send_frame(input time_t d, input time_t f, input stime_t s);
		stats_rec_t want;
		while ($urandom_range(99) < snd_idle_pct) begin
			frames_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frames_ch.valid      <= 1'b1;
		frames_ch.delta_time <= d;
		frames_ch.frame_time <= f;
		frames_ch.slack_time <= s;
		do
			@(posedge clk);
		while (!frames_ch.ready);
		fold_frame(d, f, s, want);
		pending_stats.push_back(want);
		items_sent++;
		if (want.published)
			windows_closed++;
	endtask

	// stop offering frames and wait until every stats item is back
	task automatic drain_stats();
		int n;
		n = 0;
		frames_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_stats.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (pending_stats.size() != 0) begin
			$error("%0d stats items never arrived", pending_stats.size());
			fail_count++;
			pending_stats.delete();
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_window(input time_t len);
		drain_stats();
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we  <= 1'b0;
		win_len = len;
	endtask

	task automatic set_idle(input int snd, input int rcv);
		snd_idle_pct = snd;
		rcv_idle_pct = rcv;
	endtask

	task automatic check_stat();
		stats_rec_t want;
		if (pending_stats.size() == 0) begin
			$error("stats item with no frame pending");
			fail_count++;
		end else begin
			want = pending_stats.pop_front();
			stats_checked++;
			if (stats_ch.published !== want.published) begin
				$error("published: expected %0d, got %0d",
					want.published, stats_ch.published);
				fail_count++;
			end
			if (stats_ch.average_rate !== want.average_rate) begin
				$error("average_rate: expected %0d, got %0d",
					want.average_rate, stats_ch.average_rate);
				fail_count++;
			end
			if (stats_ch.average_frame_time !== want.average_frame_time) begin
				$error("average_frame_time: expected %0d, got %0d",
					want.average_frame_time, stats_ch.average_frame_time);
				fail_count++;
			end
			if (stats_ch.worst_frame_time !== want.worst_frame_time) begin
				$error("worst_frame_time: expected %0d, got %0d",
					want.worst_frame_time, stats_ch.worst_frame_time);
				fail_count++;
			end
			if (stats_ch.least_slack_time !== want.least_slack_time) begin
				$error("least_slack_time: expected %0d, got %0d",
					want.least_slack_time, stats_ch.least_slack_time);
				fail_count++;
			end
		end
	endtask

	// stats side: check accepted items, then pick ready for the next cycle
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		stats_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && stats_ch.valid && stats_ch.ready)
				check_stat();
			if (hold_seen != hold_gen) begin
				hold_seen = hold_gen;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stats_ch.ready <= 1'b0;
			end else begin
				stats_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	task automatic random_frame(input time_t len);
		time_t  d;
		time_t  f;
		stime_t s;
		if ($urandom_range(9) < 7)
			d = time_t'($urandom_range(0, len / 3 + 1));
		else
			d = time_t'($urandom);
		if ($urandom_range(1))
			f = time_t'($urandom);
		else
			f = time_t'($urandom_range(0, 8000));
		if ($urandom_range(1))
			s = stime_t'($urandom);
		else
			s = stime_t'(int'($urandom_range(0, 4000)) - 2000);
		send_frame(d, f, s);
	endtask

	task automatic test_directed();
		set_idle(0, 0);
		// default window: nothing closes, then extremes close it at once
		send_frame('0, '0, '0);
		send_frame(TIME_MAX, TIME_MAX, SPARE_MIN);
		send_frame(24'h555555, 24'hAAAAAA, stime_t'(24'h2AAAAA));
		send_frame(24'hAAAAAA, 24'h555555, stime_t'(24'hD55555));
		// no spare below the sentinel: the minimum keeps its reset value
		send_frame('0, 24'd5, SPARE_MAX);
		send_frame(time_t'(256000), 24'd7, SPARE_MAX);
		drain_stats();
		// window of one: rate saturates
		set_window(time_t'(1));
		send_frame(time_t'(1), 24'd100, stime_t'(-1));
		send_frame('0, 24'd3, stime_t'(12));
		send_frame(time_t'(1), 24'd9, stime_t'(-300));
		// zero window: every item closes, zero elapsed gives the rate cap
		set_window('0);
		send_frame('0, 24'd100, stime_t'(-5));
		send_frame(time_t'(3), 24'd50, SPARE_MAX);
		send_frame('0, TIME_MAX, SPARE_MIN);
		// largest window, closed exactly on the boundary
		set_window(TIME_MAX);
		send_frame(TIME_MAX - 1'b1, 24'd1000, stime_t'(40));
		send_frame(time_t'(1), 24'd2000, stime_t'(-40));
		send_frame(TIME_MAX, '0, '0);
		send_frame(TIME_MAX, TIME_MAX, SPARE_MAX);
		drain_stats();
	endtask

	task automatic test_sum_saturation();
		set_window(TIME_MAX);
		set_idle(0, 0);
		repeat (300)
			send_frame('0, TIME_MAX, stime_t'($urandom));
		send_frame(TIME_MAX, '0, '0);
		drain_stats();
	endtask

	task automatic test_random_traffic();
		time_t len;
		for (int mode = 0; mode < 3; mode++) begin
			for (int k = 0; k < 3; k++) begin
				case (k)
					0: len = time_t'($urandom_range(1, 4096));
					1: len = time_t'($urandom_range(1, int'(TIME_MAX)));
					default: len = WINDOW_RESET;
				endcase
				set_window(len);
				case (mode)
					0: set_idle(16, 49);
					1: set_idle(49, 16);
					default: set_idle(0, 0);
				endcase
				repeat (PHASE_ITEMS)
					random_frame(len);
				drain_stats();
			end
		end
	endtask

	task automatic test_backpressure();
		set_window(time_t'(2000));
		set_idle(0, 0);
		hold_gen++;
		repeat (60)
			random_frame(time_t'(2000));
		drain_stats();
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		frames_ch.valid      = 1'b0;
		frames_ch.delta_time = '0;
		frames_ch.frame_time = '0;
		frames_ch.slack_time = '0;
		win_len     = WINDOW_RESET;
		shown_rate  = '0;
		shown_mean  = '0;
		shown_worst = '0;
		shown_least = '0;
		clear_accumulators();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_sum_saturation();
		test_backpressure();
		test_random_traffic();
		drain_stats();

		$display("Sent %0d frame reports, checked %0d stats items, %0d windows closed",
			items_sent, stats_checked, windows_closed);
		$display("Windows covered: zero, one, reset value, largest and random lengths");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/wfsm_pkg.sv
hdl/wfsm_if.sv
hdl/wfsm_front.sv
hdl/wfsm_fifo.sv
hdl/wfsm_div.sv
hdl/wfsm_back.sv
hdl/windowed_frame_stats_monitor_core.sv
tb/tb_windowed_frame_stats_monitor_core.sv
